FILE: rtl/core/hs_pkg.sv
// Shared types and constants of the heap sorter.
`default_nettype none
package hs_pkg;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic                    final_res;
        logic                    overflow;
    } hs_push_t;

endpackage
`default_nettype wire

FILE: rtl/core/heap_sort_top.sv
// Top level of the heap sorter with its output register.
//
//  Channel   Ports                                      Direction
//  s_        s_valid s_ready s_key s_last               in
//  m_        m_valid m_ready m_sorted_key m_final_res    out
//            m_overflow
//
// Loading takes one cycle per item; s_ready is low from the item marked last until
// the final result of the batch has been placed in the output register.
// Each sift-down step runs ST_SIFT_CHK, ST_SIFT_C1, ST_SIFT_C2 if a right child exists
// and ST_SIFT_CMP on the single store read port; read-out uses ST_EMIT_RD, ST_EMIT_WR.
// Reset is synchronous and active low; it empties the store's key count and the output.
// A stalled result holds the sequencer only during read-out.
`default_nettype none
module heap_sort_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [hs_pkg::KEY_W-1:0] s_key,
    input  wire logic                            s_last,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [hs_pkg::KEY_W-1:0]      m_sorted_key,
    output logic                                 m_final_res,
    output logic                                 m_overflow
);
    import hs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    hs_push_t                push;
    logic                    out_free;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic [AW-1:0]           rd_addr;
    logic signed [KEY_W-1:0] rd_data;

    logic                    m_valid_reg, m_valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic                    final_reg;
    logic                    overflow_reg;

    hs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_key    (s_key),
        .s_last   (s_last),
        .out_free (out_free),
        .push     (push),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (push.valid) begin
            key_reg      <= push.key;
            final_reg    <= push.final_res;
            overflow_reg <= push.overflow;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sorted_key = key_reg;
    assign m_final_res  = final_reg;
    assign m_overflow   = overflow_reg;

endmodule
`default_nettype wire

FILE: rtl/core/hs_store.sv
// Key store of the heap sorter: one write port and one registered read port.
`default_nettype none
module hs_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic signed [hs_pkg::KEY_W-1:0] wr_data,
    input  wire logic [AW-1:0]                  rd_addr,
    output logic signed [hs_pkg::KEY_W-1:0]     rd_data
);
    import hs_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/core/hs_ctrl.sv
// Sequencer of the heap sorter: loading, heap build, sort-down and read-out.
`default_nettype none
module hs_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [hs_pkg::KEY_W-1:0] s_key,
    input  wire logic                            s_last,
    input  wire logic                            out_free,
    output hs_pkg::hs_push_t                     push,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic signed [hs_pkg::KEY_W-1:0]      wr_data,
    output logic [AW-1:0]                        rd_addr,
    input  wire logic signed [hs_pkg::KEY_W-1:0] rd_data
);
    import hs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;

    typedef enum logic [3:0] {
        ST_LOAD, ST_BUILD_RD, ST_HELD, ST_SWAP_RD_LAST, ST_SWAP_RD_ROOT, ST_SWAP_WR,
        ST_SIFT_CHK, ST_SIFT_C1, ST_SIFT_C2, ST_SIFT_CMP, ST_EMIT_RD, ST_EMIT_WR
    } state_t;

    typedef enum logic {
        PH_BUILD, PH_SORT
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [IW-1:0]           child_reg, child_next;
    logic [CW-1:0]           bottom_reg, bottom_next;
    logic [CW-1:0]           sel_reg, sel_next;
    logic signed [KEY_W-1:0] held_reg, held_next;
    logic signed [KEY_W-1:0] big_reg, big_next;

    logic [CW-1:0]           load_cnt;
    logic [CW-1:0]           idx_dec;
    logic                    sift_done;
    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic                    cmp_lt;

    assign cmp_lt  = cmp_a < cmp_b;
    assign idx_dec = idx_reg - CW'(1);
    assign s_ready = (state_reg == ST_LOAD);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        child_next   = child_reg;
        bottom_next  = bottom_reg;
        sel_next     = sel_reg;
        held_next    = held_reg;
        big_next     = big_reg;
        load_cnt     = count_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = held_reg;
        rd_addr      = '0;
        push         = '0;
        cmp_a        = held_reg;
        cmp_b        = big_reg;
        sift_done    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CW'(DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_reg);
                        wr_data  = s_key;
                        load_cnt = count_reg + CW'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    count_next = load_cnt;
                    if (s_last) begin
                        n_next     = load_cnt;
                        phase_next = PH_BUILD;
                        if ((load_cnt >> 1) == '0) begin
                            idx_next   = '0;
                            state_next = ST_EMIT_RD;
                        end else begin
                            idx_next   = load_cnt >> 1;
                            state_next = ST_BUILD_RD;
                        end
                    end
                end
            end
            ST_BUILD_RD: begin
                rd_addr     = AW'(idx_dec);
                pos_next    = idx_reg;
                child_next  = {idx_reg, 1'b0};
                bottom_next = n_reg;
                state_next  = ST_HELD;
            end
            ST_HELD: begin
                held_next  = rd_data;
                state_next = ST_SIFT_CHK;
            end
            ST_SWAP_RD_LAST: begin
                rd_addr    = AW'(idx_dec);
                state_next = ST_SWAP_RD_ROOT;
            end
            ST_SWAP_RD_ROOT: begin
                rd_addr    = '0;
                held_next  = rd_data;
                state_next = ST_SWAP_WR;
            end
            ST_SWAP_WR: begin
                wr_en       = 1'b1;
                wr_addr     = AW'(idx_dec);
                wr_data     = rd_data;
                pos_next    = CW'(1);
                child_next  = IW'(2);
                bottom_next = idx_dec;
                state_next  = ST_SIFT_CHK;
            end
            ST_SIFT_CHK: begin
                if (child_reg > IW'(bottom_reg)) begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(pos_reg - CW'(1));
                    wr_data   = held_reg;
                    sift_done = 1'b1;
                end else begin
                    rd_addr    = AW'(child_reg - IW'(1));
                    state_next = ST_SIFT_C1;
                end
            end
            ST_SIFT_C1: begin
                big_next = rd_data;
                sel_next = CW'(child_reg);
                if (child_reg < IW'(bottom_reg)) begin
                    rd_addr    = AW'(child_reg);
                    state_next = ST_SIFT_C2;
                end else begin
                    state_next = ST_SIFT_CMP;
                end
            end
            ST_SIFT_C2: begin
                cmp_a = big_reg;
                cmp_b = rd_data;
                if (cmp_lt) begin
                    big_next = rd_data;
                    sel_next = CW'(child_reg) + CW'(1);
                end
                state_next = ST_SIFT_CMP;
            end
            ST_SIFT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - CW'(1));
                if (cmp_lt) begin
                    wr_data    = big_reg;
                    pos_next   = sel_reg;
                    child_next = {sel_reg, 1'b0};
                    state_next = ST_SIFT_CHK;
                end else begin
                    wr_data   = held_reg;
                    sift_done = 1'b1;
                end
            end
            ST_EMIT_RD: begin
                if (out_free) begin
                    rd_addr    = AW'(idx_reg);
                    state_next = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR: begin
                push.valid     = 1'b1;
                push.key       = rd_data;
                push.final_res = (idx_reg == n_reg - CW'(1));
                push.overflow  = dropped_reg;
                if (push.final_res) begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (sift_done) begin
            if (phase_reg == PH_BUILD && idx_reg != CW'(1)) begin
                idx_next   = idx_dec;
                state_next = ST_BUILD_RD;
            end else begin
                phase_next = PH_SORT;
                if (phase_reg == PH_BUILD) begin
                    idx_next = n_reg;
                end else begin
                    idx_next = idx_dec;
                end
                if (idx_next > CW'(1)) begin
                    state_next = ST_SWAP_RD_LAST;
                end else begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            phase_reg   <= PH_BUILD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            n_reg       <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            n_reg       <= n_next;
            idx_reg     <= idx_next;
        end
        pos_reg    <= pos_next;
        child_reg  <= child_next;
        bottom_reg <= bottom_next;
        sel_reg    <= sel_next;
        held_reg   <= held_next;
        big_reg    <= big_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("key count exceeds the store depth");

    a_pos_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIFT_CHK) |-> (pos_reg != '0 && pos_reg <= bottom_reg))
        else $error("sift position outside the heap");

    a_emit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_WR) |-> (idx_reg < n_reg))
        else $error("read-out index beyond the batch");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> $past(out_free))
        else $error("item pushed without a free output slot");

    a_final_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && push.final_res) |=> (s_ready && count_reg == '0))
        else $error("batch end does not return to loading");

endmodule
`default_nettype wire
